FILE: rtl/efb_pkg.sv
// shared types, constants and crc function for the ethernet frame fcs builder
`timescale 1ns / 1ps
package efb_pkg;

  localparam int COUNT_WIDTH_DEF = 11;
  localparam int LEN_W           = 11;
  localparam int MAC_W           = 48;
  localparam int ETYPE_W         = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int QDEPTH          = 4;
  localparam int HDR_BYTES       = 14;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [MAC_W-1:0]   DST_MAC_RST     = 48'h000973077473;
  localparam logic [MAC_W-1:0]   SRC_MAC_RST     = 48'h0009730773F9;
  localparam logic [ETYPE_W-1:0] ETHER_TYPE_RST  = 16'h0800;
  localparam logic [LEN_W-1:0]   MIN_PAYLOAD_RST = 11'd46;
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RST = 11'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DST_MAC     = 3'd0,
    REG_SRC_MAC     = 3'd1,
    REG_ETHER_TYPE  = 3'd2,
    REG_MIN_PAYLOAD = 3'd3,
    REG_MAX_PAYLOAD = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_HDR = 2'd0,
    SRC_PAY = 2'd1,
    SRC_FCS = 2'd2
  } src_t;

  typedef struct packed {
    logic [MAC_W-1:0]   dst_mac;
    logic [MAC_W-1:0]   src_mac;
    logic [ETYPE_W-1:0] ether_type;
    logic [LEN_W-1:0]   min_payload;
    logic [LEN_W-1:0]   max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/efb_if.sv
// stream interfaces for payload input and frame output
`timescale 1ns / 1ps
interface efb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface efb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_source;
  logic       end_of_frame;
  logic       length_error;

  modport source (output valid, output out_byte, output byte_source, output end_of_frame,
                  output length_error, input ready);
  modport sink   (input valid, input out_byte, input byte_source, input end_of_frame,
                  input length_error, output ready);
endinterface

FILE: rtl/efb_front.sv
// input side: accepts payload bytes, marks frame starts, queues them for the back end
`timescale 1ns / 1ps
module efb_front (
  input  logic           clk,
  input  logic           rst_n,
  efb_in_if.sink         in_ch,
  output efb_pkg::q_head_t head,
  input  logic           q_pop
);

  localparam int PtrW = $clog2(efb_pkg::QDEPTH);

  efb_pkg::q_item_t mem_r [efb_pkg::QDEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [PtrW:0]    count_r;
  logic [PtrW:0]    count_nxt;
  logic             mid_r;
  logic             push;

  assign in_ch.ready = (count_r != (PtrW+1)'(efb_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign count_nxt   = count_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);

  assign head.valid  = (count_r != '0);
  assign head.item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_ch.data_byte, last: in_ch.last_byte, first: !mid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      mid_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
        mid_r    <= !in_ch.last_byte;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/efb_back.sv
// output side: header, payload and fcs sequencer with running crc and output register
`timescale 1ns / 1ps
module efb_back #(
  parameter int COUNT_WIDTH = efb_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  efb_pkg::cfg_t    cfg,
  input  efb_pkg::q_head_t head,
  output logic             q_pop,
  efb_out_if.source        out_ch
);

  localparam int CmpW = (COUNT_WIDTH > efb_pkg::LEN_W) ? COUNT_WIDTH : efb_pkg::LEN_W;
  localparam logic [3:0] HdrLast = 4'(efb_pkg::HDR_BYTES - 1);

  typedef enum logic [3:0] {
    ST_WAIT = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_FCS  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [3:0]             hdr_idx_r, hdr_idx_nxt;
  logic [1:0]             fcs_idx_r, fcs_idx_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] byte_source_r;
  logic       end_of_frame_r;
  logic       length_error_r;

  logic                                 adv;
  logic                                 emit;
  logic                                 pay_emit;
  logic                                 crc_upd;
  logic [7:0]                           byte_v;
  efb_pkg::src_t                        src_v;
  logic                                 eof_v;
  logic                                 err_v;
  logic [8*efb_pkg::HDR_BYTES-1:0]      hdr_vec;
  logic [7:0]                           hdr_byte;
  logic [31:0]                          fcs;
  logic [7:0]                           fcs_byte;
  logic                                 len_bad;

  assign adv      = !out_valid_r || out_ch.ready;
  assign hdr_vec  = {cfg.dst_mac, cfg.src_mac, cfg.ether_type};
  assign fcs      = ~crc_r;
  assign fcs_byte = fcs[8*fcs_idx_r +: 8];
  assign len_bad  = (CmpW'(cnt_r) < CmpW'(cfg.min_payload)) ||
                    (CmpW'(cnt_r) > CmpW'(cfg.max_payload));

  always_comb begin
    hdr_byte = '0;
    for (int k = 0; k < efb_pkg::HDR_BYTES; k++) begin
      if (hdr_idx_r == 4'(k)) begin
        hdr_byte = hdr_vec[8*(efb_pkg::HDR_BYTES-1-k) +: 8];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    hdr_idx_nxt = hdr_idx_r;
    fcs_idx_nxt = fcs_idx_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    pay_emit    = 1'b0;
    crc_upd     = 1'b0;
    byte_v      = hdr_byte;
    src_v       = efb_pkg::SRC_HDR;
    eof_v       = 1'b0;
    err_v       = 1'b0;

    case (state_r)
      ST_WAIT: begin
        if (adv && head.valid) begin
          if (head.item.first) begin
            emit        = 1'b1;
            crc_upd     = 1'b1;
            hdr_idx_nxt = hdr_idx_r + 1'b1;
            state_nxt   = ST_HDR;
          end else begin
            pay_emit = 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (adv) begin
          emit    = 1'b1;
          crc_upd = 1'b1;
          if (hdr_idx_r == HdrLast) begin
            hdr_idx_nxt = '0;
            state_nxt   = ST_DATA;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (adv && head.valid) begin
          pay_emit = 1'b1;
        end
      end
      ST_FCS: begin
        if (adv) begin
          emit   = 1'b1;
          byte_v = fcs_byte;
          src_v  = efb_pkg::SRC_FCS;
          if (fcs_idx_r == 2'd3) begin
            eof_v       = 1'b1;
            err_v       = len_bad;
            crc_nxt     = efb_pkg::CRC_ONES;
            cnt_nxt     = '0;
            fcs_idx_nxt = '0;
            state_nxt   = ST_WAIT;
          end else begin
            fcs_idx_nxt = fcs_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase

    if (pay_emit) begin
      emit        = 1'b1;
      crc_upd     = 1'b1;
      q_pop       = 1'b1;
      byte_v      = head.item.data;
      src_v       = efb_pkg::SRC_PAY;
      fcs_idx_nxt = '0;
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      state_nxt = head.item.last ? ST_FCS : ST_WAIT;
    end

    if (crc_upd) begin
      crc_nxt = efb_pkg::crc_byte(crc_r, byte_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      hdr_idx_r   <= '0;
      fcs_idx_r   <= '0;
      crc_r       <= efb_pkg::CRC_ONES;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      fcs_idx_r <= fcs_idx_nxt;
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r     <= byte_v;
      byte_source_r  <= src_v;
      end_of_frame_r <= eof_v;
      length_error_r <= err_v;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.byte_source  = byte_source_r;
  assign out_ch.end_of_frame = end_of_frame_r;
  assign out_ch.length_error = length_error_r;

endmodule

FILE: rtl/ethernet_frame_fcs_builder.sv
// top level: configuration registers, input queue front end and frame sequencer
// path: a payload byte passes through the input queue and the output register, and the
//   first byte of a frame waits behind the header
// throughput: one output byte per cycle from the single output register while the receiver
//   is ready; a frame of n payload bytes gives 14 header, n payload and 4 fcs bytes, input
//   takes one byte per cycle while the 4-entry queue has room
// reset: synchronous, active low; clears queue, sequencer and crc, loads register defaults
`timescale 1ns / 1ps
module ethernet_frame_fcs_builder #(
  parameter int COUNT_WIDTH = efb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  efb_in_if.sink                         in_ch,
  efb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [efb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efb_pkg::MAC_W-1:0]      cfg_data
);

  efb_pkg::cfg_t    cfg_r;
  efb_pkg::q_head_t head;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dst_mac     <= efb_pkg::DST_MAC_RST;
      cfg_r.src_mac     <= efb_pkg::SRC_MAC_RST;
      cfg_r.ether_type  <= efb_pkg::ETHER_TYPE_RST;
      cfg_r.min_payload <= efb_pkg::MIN_PAYLOAD_RST;
      cfg_r.max_payload <= efb_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efb_pkg::REG_DST_MAC:     cfg_r.dst_mac     <= cfg_data;
        efb_pkg::REG_SRC_MAC:     cfg_r.src_mac     <= cfg_data;
        efb_pkg::REG_ETHER_TYPE:  cfg_r.ether_type  <= cfg_data[efb_pkg::ETYPE_W-1:0];
        efb_pkg::REG_MIN_PAYLOAD: cfg_r.min_payload <= cfg_data[efb_pkg::LEN_W-1:0];
        efb_pkg::REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_data[efb_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  efb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .q_pop (q_pop)
  );

  efb_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head.valid)
    else $error("queue pop while empty");

  a_eof_is_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_frame) |-> (out_ch.byte_source == efb_pkg::SRC_FCS))
    else $error("end of frame on a non-fcs byte");

  a_err_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.length_error) |-> out_ch.end_of_frame)
    else $error("length error away from end of frame");

  a_pop_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_ch.valid && out_ch.byte_source == efb_pkg::SRC_PAY))
    else $error("popped item not shown as payload byte");

endmodule

FILE: sim/frame_checker.sv
// frame checker: predicts the ethernet frame bytes from payload transfers and compares them
`timescale 1ns / 1ps
module frame_checker #(
  parameter int COUNT_WIDTH = efb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efb_in_if                             in_ch,
  efb_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efb_pkg::MAC_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            checked_bytes,
  output int                            flagged_frames
);

  typedef struct packed {
    logic [7:0]    data;
    efb_pkg::src_t src;
    logic          eof;
    logic          len_err;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  logic [efb_pkg::MAC_W-1:0]   dst_mac;
  logic [efb_pkg::MAC_W-1:0]   src_mac;
  logic [efb_pkg::ETYPE_W-1:0] ether_type;
  logic [efb_pkg::LEN_W-1:0]   min_len;
  logic [efb_pkg::LEN_W-1:0]   max_len;
  logic [31:0]                 running_crc;
  logic [COUNT_WIDTH-1:0]      pay_count;
  bit                          header_sent;

  initial begin
    mismatches     = 0;
    outstanding    = 0;
    checked_bytes  = 0;
    flagged_frames = 0;
  end

  // bit-serial form of the reflected crc-32
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ efb_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  task automatic add_crc_byte(input logic [7:0] b, input efb_pkg::src_t src);
    running_crc = crc_update(running_crc, b);
    expected_bytes.push_back('{data: b, src: src, eof: 1'b0, len_err: 1'b0});
  endtask

  task automatic predict_frame_bytes(input logic [7:0] d, input logic last);
    logic [31:0] fcs;
    logic        err;
    if (!header_sent) begin
      for (int i = 5; i >= 0; i--) add_crc_byte(dst_mac[8*i +: 8], efb_pkg::SRC_HDR);
      for (int i = 5; i >= 0; i--) add_crc_byte(src_mac[8*i +: 8], efb_pkg::SRC_HDR);
      add_crc_byte(ether_type[15:8], efb_pkg::SRC_HDR);
      add_crc_byte(ether_type[7:0], efb_pkg::SRC_HDR);
      header_sent = 1'b1;
    end
    add_crc_byte(d, efb_pkg::SRC_PAY);
    if (pay_count != '1) begin
      pay_count = pay_count + 1'b1;
    end
    if (last) begin
      fcs = ~running_crc;
      err = (pay_count < min_len) || (pay_count > max_len);
      for (int i = 0; i < 4; i++) begin
        expected_bytes.push_back('{data: fcs[8*i +: 8], src: efb_pkg::SRC_FCS, eof: (i == 3),
                                   len_err: (i == 3) && err});
      end
      running_crc = efb_pkg::CRC_ONES;
      pay_count   = '0;
      header_sent = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (!rst_n) begin
      dst_mac     = efb_pkg::DST_MAC_RST;
      src_mac     = efb_pkg::SRC_MAC_RST;
      ether_type  = efb_pkg::ETHER_TYPE_RST;
      min_len     = efb_pkg::MIN_PAYLOAD_RST;
      max_len     = efb_pkg::MAX_PAYLOAD_RST;
      running_crc = efb_pkg::CRC_ONES;
      pay_count   = '0;
      header_sent = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (efb_pkg::cfg_idx_t'(cfg_index))
          efb_pkg::REG_DST_MAC:     dst_mac = cfg_data;
          efb_pkg::REG_SRC_MAC:     src_mac = cfg_data;
          efb_pkg::REG_ETHER_TYPE:  ether_type = cfg_data[efb_pkg::ETYPE_W-1:0];
          efb_pkg::REG_MIN_PAYLOAD: min_len = cfg_data[efb_pkg::LEN_W-1:0];
          efb_pkg::REG_MAX_PAYLOAD: max_len = cfg_data[efb_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_bytes(in_ch.data_byte, in_ch.last_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        checked_bytes++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t unexpected frame byte %02h src %0d eof %b err %b", $time,
                   out_ch.out_byte, out_ch.byte_source, out_ch.end_of_frame,
                   out_ch.length_error);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (exp_b.eof && exp_b.len_err) begin
            flagged_frames++;
          end
          if (out_ch.out_byte !== exp_b.data || out_ch.byte_source !== exp_b.src ||
              out_ch.end_of_frame !== exp_b.eof || out_ch.length_error !== exp_b.len_err) begin
            mismatches++;
            $display("%0t exp %02h src %0d eof %b err %b, got %02h src %0d eof %b err %b",
                     $time, exp_b.data, exp_b.src, exp_b.eof, exp_b.len_err,
                     out_ch.out_byte, out_ch.byte_source, out_ch.end_of_frame,
                     out_ch.length_error);
          end
        end
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

FILE: sim/tb.sv
// testbench top: clock, reset, payload stimulus, register writes and final verdict
`timescale 1ns / 1ps
module tb;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PER_MIX  = 100;

  localparam logic [efb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [efb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [efb_pkg::MAC_W-1:0]     cfg_data;

  efb_in_if  in_ch ();
  efb_out_if out_ch ();

  int mismatches;
  int outstanding;
  int checked_bytes;
  int flagged_frames;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_grants    = 0;
  int cur_min        = efb_pkg::MIN_PAYLOAD_RST;
  int cur_max        = efb_pkg::MAX_PAYLOAD_RST;
  int frames_sent    = 0;
  int payload_sent   = 0;
  int idle_cycles    = 0;

  always #(CLK_HALF) clk = ~clk;

  ethernet_frame_fcs_builder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked_bytes  (checked_bytes),
    .flagged_frames (flagged_frames)
  );

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_grants) begin
        hold_seen = hold_grants;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [efb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [efb_pkg::MAC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input logic [efb_pkg::MAC_W-1:0] dmac,
                             input logic [efb_pkg::MAC_W-1:0] smac,
                             input logic [efb_pkg::ETYPE_W-1:0] etype,
                             input int min_l, input int max_l);
    write_reg(efb_pkg::REG_DST_MAC, dmac);
    write_reg(efb_pkg::REG_SRC_MAC, smac);
    write_reg(efb_pkg::REG_ETHER_TYPE, {32'h0, etype});
    write_reg(efb_pkg::REG_MIN_PAYLOAD, efb_pkg::MAC_W'(min_l));
    write_reg(efb_pkg::REG_MAX_PAYLOAD, efb_pkg::MAC_W'(max_l));
    cur_min = min_l;
    cur_max = max_l;
  endtask

  task automatic send_payload(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    payload_sent++;
    if (last) begin
      frames_sent++;
    end
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_payload(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // mostly short frames, some right around the current length bounds
  task automatic send_random_frames(input int target);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(1, 12);
      end else if (r < 85) begin
        len = ((r < 72) ? cur_min : cur_max) + $urandom_range(4) - 2;
        if (len < 1 || len > 80) begin
          len = $urandom_range(13, 40);
        end
      end else begin
        len = $urandom_range(13, 40);
      end
      send_frame(len);
      sent += len;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [efb_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[efb_pkg::MAC_W-1:0];
  endfunction

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults: single-byte frames and a short frame, all under the minimum
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'hA5, 1'b1);
    settle();

    // widest bounds, all-ones header fields
    load_config({efb_pkg::MAC_W{1'b1}}, {efb_pkg::MAC_W{1'b1}}, 16'hFFFF, 0, 2047);
    send_payload(8'hFF, 1'b1);
    send_frame(3);
    settle();

    // inverted bounds flag every length, all-zero header fields
    load_config('0, '0, 16'h0000, 2047, 0);
    send_frame(2);
    settle();

    // writes to unused indexes must change nothing
    write_reg(REG_SPARE_LO, {efb_pkg::MAC_W{1'b1}});
    write_reg(REG_SPARE_HI, rand_mac());
    send_payload(8'h5A, 1'b1);
    settle();

    // lengths just inside and outside the bounds
    load_config(rand_mac(), rand_mac(), 16'h86DD, 3, 4);
    send_frame(2);
    send_frame(3);
    send_frame(4);
    send_frame(5);
    settle();

    // random frames under four handshake mixes, with a long receiver hold-off first
    load_config(rand_mac(), rand_mac(), 16'($urandom), 2, 9);
    hold_grants++;
    send_random_frames(RANDOM_PER_MIX);
    settle();

    send_idle_pct = 83;
    load_config(rand_mac(), rand_mac(), 16'($urandom), 10, 12);
    send_random_frames(RANDOM_PER_MIX);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    load_config(rand_mac(), rand_mac(), 16'($urandom), 1, 6);
    send_random_frames(RANDOM_PER_MIX);
    settle();

    send_idle_pct  = 36;
    recv_stall_pct = 36;
    load_config(efb_pkg::DST_MAC_RST, efb_pkg::SRC_MAC_RST, efb_pkg::ETHER_TYPE_RST,
                efb_pkg::MIN_PAYLOAD_RST, efb_pkg::MAX_PAYLOAD_RST);
    send_random_frames(RANDOM_PER_MIX);
    settle();

    repeat (20) @(negedge clk);
    $display("covered %0d frames with %0d payload bytes, %0d frame bytes checked,",
             frames_sent, payload_sent, checked_bytes);
    $display("%0d length flags seen, under four idling mixes and register changes",
             flagged_frames);
    if (outstanding != 0) begin
      $display("%0t %0d frame bytes still expected", $time, outstanding);
    end
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: ethernet_frame_fcs_builder.f
rtl/efb_pkg.sv
rtl/efb_if.sv
rtl/efb_front.sv
rtl/efb_back.sv
rtl/ethernet_frame_fcs_builder.sv
sim/frame_checker.sv
sim/tb.sv
